### rtl/stack_chunk_allocator_defines.svh
// Assertion macros shared by the stack chunk allocator modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef STACK_CHUNK_ALLOCATOR_DEFINES_SVH
`define STACK_CHUNK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define SCA_ASSERT_COND(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sca assertion failed");
// A condition that must hold in the cycle after a trigger.
`define SCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sca assertion failed");
`else
`define SCA_ASSERT_COND(lbl, clk, rst_n, cond)
`define SCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/sca_pkg.sv
// Package for the stack chunk allocator: field widths, default parameters,
// operation and status codes, controller states and the control struct.
`timescale 1ns / 1ps
package sca_pkg;

    localparam int REQ_W       = 20;
    localparam int CAP_W       = 20;
    localparam int OUT_ADDR_W  = 20;
    localparam int COUNT_W     = 7;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 20'hFFFFF;

    localparam int DEF_MAX_CHUNKS   = 64;
    localparam int DEF_ADDR_BITS    = 20;
    localparam int DEF_HEADER_BYTES = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        SCA_IDLE = 1'b0,
        SCA_EXEC = 1'b1
    } state_t;

    // Strobes from the controller to the datapath.
    typedef struct packed {
        logic accept;  // item taken this cycle; issue the size stack read
        logic exec;    // apply the held item and load the result register
    } ctrl_t;

endpackage

### rtl/sca_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module sca_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/sca_ctrl.sv
// Controller of the stack chunk allocator: two-state sequencer and result
// valid register. Depends on sca_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "stack_chunk_allocator_defines.svh"
module sca_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output sca_pkg::ctrl_t ctl
);

    sca_pkg::state_t state_reg;
    sca_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sca_pkg::SCA_IDLE:
            begin
                if (ctl.accept)
                begin
                    state_next = sca_pkg::SCA_EXEC;
                end
            end
            sca_pkg::SCA_EXEC:
            begin
                if (ctl.exec)
                begin
                    state_next = sca_pkg::SCA_IDLE;
                end
            end
            default:
            begin
                state_next = sca_pkg::SCA_IDLE;
            end
        endcase
    end

    // The result register may be reloaded when it is empty or drains now.
    always_comb
    begin
        in_stall   = 1'b1;
        ctl.accept = 1'b0;
        ctl.exec   = 1'b0;
        case (state_reg)
            sca_pkg::SCA_IDLE:
            begin
                in_stall   = 1'b0;
                ctl.accept = in_valid;
            end
            sca_pkg::SCA_EXEC:
            begin
                ctl.exec = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sca_pkg::SCA_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `SCA_ASSERT_NEXT(a_accept_enters_exec, clk, rst_n, ctl.accept, state_reg == sca_pkg::SCA_EXEC)
    `SCA_ASSERT_NEXT(a_exec_frees_input, clk, rst_n, ctl.exec, !in_stall && out_valid)
    `SCA_ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !out_valid_reg && !ctl.exec, !out_valid_reg)

endmodule

### rtl/sca_dp.sv
// Datapath of the stack chunk allocator: top-of-stack registers, capacity
// register, size stack RAM and result registers. Depends on sca_pkg, sca_ram
// and the assertion macro header.
`timescale 1ns / 1ps
`include "stack_chunk_allocator_defines.svh"
module sca_dp #(
    parameter int MAX_CHUNKS   = sca_pkg::DEF_MAX_CHUNKS,
    parameter int ADDR_BITS    = sca_pkg::DEF_ADDR_BITS,
    parameter int HEADER_BYTES = sca_pkg::DEF_HEADER_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sca_pkg::ctrl_t                   ctl,
    input  logic [sca_pkg::KIND_W-1:0]       kind,
    input  logic [sca_pkg::REQ_W-1:0]        request_bytes,
    input  logic                             cfg_we,
    input  logic [sca_pkg::CAP_W-1:0]        cfg_wdata,
    output logic [sca_pkg::OUT_ADDR_W-1:0]   address,
    output logic                             address_valid,
    output logic [sca_pkg::STATUS_W-1:0]     status,
    output logic [sca_pkg::COUNT_W-1:0]      chunk_count
);

    localparam int AW   = ADDR_BITS;
    localparam int LW   = $clog2(MAX_CHUNKS + 1);
    localparam int IW   = $clog2(MAX_CHUNKS);
    localparam int NW   = sca_pkg::REQ_W + 1;
    localparam int CMPW = ((AW > NW) ? AW : NW) + 1;
    localparam int AXW  = (AW > sca_pkg::OUT_ADDR_W) ? AW : sca_pkg::OUT_ADDR_W;
    localparam int CXW  = (LW > sca_pkg::COUNT_W) ? LW : sca_pkg::COUNT_W;

    logic [sca_pkg::CAP_W-1:0]  cap_reg;
    logic [AW-1:0]              top_reg;
    logic [AW-1:0]              top_next;
    logic [sca_pkg::REQ_W-1:0]  bytes_reg;
    logic [sca_pkg::REQ_W-1:0]  bytes_next;
    logic [AW-1:0]              used_reg;
    logic [AW-1:0]              used_next;
    logic [LW-1:0]              live_reg;
    logic [LW-1:0]              live_next;
    logic [sca_pkg::KIND_W-1:0] kind_reg;
    logic [sca_pkg::REQ_W-1:0]  req_reg;
    logic [sca_pkg::STATUS_W-1:0] status_next;

    logic [NW-1:0]              need;
    logic [CMPW-1:0]            cap_ext;
    logic [CMPW-1:0]            used_ext;
    logic [CMPW-1:0]            avail;
    logic                       no_space;
    logic                       full;
    logic                       push;
    logic [sca_pkg::REQ_W-1:0]  below;
    logic [AXW-1:0]             addr_ext;
    logic [CXW-1:0]             count_ext;

    sca_ram #(
        .WIDTH (sca_pkg::REQ_W),
        .DEPTH (MAX_CHUNKS)
    ) u_size_stack (
        .clk   (clk),
        .we    (push),
        .waddr (live_reg[IW-1:0]),
        .wdata (req_reg),
        .re    (ctl.accept),
        .raddr (IW'(live_reg - LW'(2))),
        .rdata (below)
    );

    assign need     = NW'(req_reg) + NW'(HEADER_BYTES);
    assign cap_ext  = CMPW'(cap_reg);
    assign used_ext = CMPW'(used_reg);
    assign avail    = (cap_ext > used_ext) ? (cap_ext - used_ext) : '0;
    assign no_space = CMPW'(need) > avail;
    assign full     = live_reg >= LW'(MAX_CHUNKS);
    assign push     = ctl.exec && (kind_reg == sca_pkg::KIND_ALLOC) && !no_space && !full;

    always_comb
    begin
        top_next    = top_reg;
        bytes_next  = bytes_reg;
        used_next   = used_reg;
        live_next   = live_reg;
        status_next = sca_pkg::ST_OK;
        case (kind_reg)
            sca_pkg::KIND_ALLOC:
            begin
                if (no_space)
                begin
                    status_next = sca_pkg::ST_NO_SPACE;
                end
                else if (full)
                begin
                    status_next = sca_pkg::ST_FULL;
                end
                else
                begin
                    top_next   = (live_reg == '0) ? '0
                               : top_reg + AW'(bytes_reg) + AW'(HEADER_BYTES);
                    bytes_next = req_reg;
                    used_next  = used_reg + AW'(need);
                    live_next  = live_reg + LW'(1);
                end
            end
            sca_pkg::KIND_FREE:
            begin
                if (live_reg == '0)
                begin
                    status_next = sca_pkg::ST_EMPTY;
                end
                else
                begin
                    used_next = used_reg - AW'(bytes_reg) - AW'(HEADER_BYTES);
                    live_next = live_reg - LW'(1);
                    if (live_reg == LW'(1))
                    begin
                        top_next   = '0;
                        bytes_next = '0;
                    end
                    else
                    begin
                        top_next   = top_reg - AW'(below) - AW'(HEADER_BYTES);
                        bytes_next = below;
                    end
                end
            end
            sca_pkg::KIND_CLEAR:
            begin
                top_next   = '0;
                bytes_next = '0;
                used_next  = '0;
                live_next  = '0;
            end
            default:
            begin
                status_next = sca_pkg::ST_OK;
            end
        endcase
    end

    assign addr_ext  = AXW'(top_next);
    assign count_ext = CXW'(live_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= sca_pkg::CAP_RESET;
            top_reg   <= '0;
            bytes_reg <= '0;
            used_reg  <= '0;
            live_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (ctl.exec)
            begin
                top_reg   <= top_next;
                bytes_reg <= bytes_next;
                used_reg  <= used_next;
                live_reg  <= live_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            kind_reg <= kind;
            req_reg  <= request_bytes;
        end
        if (ctl.exec)
        begin
            address       <= (live_next != '0) ? addr_ext[sca_pkg::OUT_ADDR_W-1:0] : '0;
            address_valid <= live_next != '0;
            status        <= status_next;
            chunk_count   <= count_ext[sca_pkg::COUNT_W-1:0];
        end
    end

    `SCA_ASSERT_COND(a_live_bounded, clk, rst_n, live_reg <= LW'(MAX_CHUNKS))
    `SCA_ASSERT_COND(a_empty_top_zero, clk, rst_n, live_reg != '0 || (top_reg == '0 && bytes_reg == '0))
    `SCA_ASSERT_NEXT(a_valid_tracks_live, clk, rst_n, ctl.exec, address_valid == (live_reg != '0))

endmodule

### rtl/stack_chunk_allocator.sv
// Top level of the stack chunk allocator, a LIFO bump allocator over a byte
// region. Depends on sca_pkg, sca_ctrl and sca_dp (which holds sca_ram).
`timescale 1ns / 1ps
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | kind, request_bytes
//  result   | out_valid / out_stall| address, address_valid, status, chunk_count
//  config   | cfg_we               | cfg_wdata (capacity_bytes)
//
// Each item is handled in an accept step and an execute step: the accept edge
// issues the read of the size stack entry below the top, and the execute edge
// applies the operation, writes a pushed size and loads the result register.
// The registered read of the size stack RAM makes these separate steps; a new
// item is not taken until the last one has executed.
// Reset clears the stack to empty and loads the capacity with its full value.
// The size stack needs no clearing pass: only entries below the live count
// are ever used, and each of those was written by a push.
// A stalled result holds in its register; the next item is still accepted and
// waits for execution until the register drains.
module stack_chunk_allocator #(
    parameter int MAX_CHUNKS   = sca_pkg::DEF_MAX_CHUNKS,
    parameter int ADDR_BITS    = sca_pkg::DEF_ADDR_BITS,
    parameter int HEADER_BYTES = sca_pkg::DEF_HEADER_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [sca_pkg::KIND_W-1:0]       kind,
    input  logic [sca_pkg::REQ_W-1:0]        request_bytes,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [sca_pkg::OUT_ADDR_W-1:0]   address,
    output logic                             address_valid,
    output logic [sca_pkg::STATUS_W-1:0]     status,
    output logic [sca_pkg::COUNT_W-1:0]      chunk_count,
    input  logic                             cfg_we,
    input  logic [sca_pkg::CAP_W-1:0]        cfg_wdata
);

    // Accept and execute strobes from the sequencer to the datapath.
    sca_pkg::ctrl_t ctl;

    sca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // The datapath keeps the top chunk offset and size, the used byte count
    // and the live chunk count in registers, and the sizes of the chunks below
    // the top in the size stack RAM.
    sca_dp #(
        .MAX_CHUNKS   (MAX_CHUNKS),
        .ADDR_BITS    (ADDR_BITS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .kind          (kind),
        .request_bytes (request_bytes),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .address       (address),
        .address_valid (address_valid),
        .status        (status),
        .chunk_count   (chunk_count)
    );

endmodule

### sim/testbench.sv
// Self-checking testbench for the stack chunk allocator: directed and random
// allocate, free and clear items, checked against a cycle-free predictor.
// Depends on sca_pkg and the stack_chunk_allocator RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int REQ_W    = sca_pkg::REQ_W;
    localparam int CAP_W    = sca_pkg::CAP_W;
    localparam int KIND_W   = sca_pkg::KIND_W;
    localparam int OUT_W    = sca_pkg::OUT_ADDR_W;
    localparam int CNT_W    = sca_pkg::COUNT_W;
    localparam int STS_W    = sca_pkg::STATUS_W;
    localparam int NEED_W   = REQ_W + 2;
    localparam int HEADER = sca_pkg::DEF_HEADER_BYTES;
    localparam int STACK_DEPTH = sca_pkg::DEF_MAX_CHUNKS;
    localparam int IDX_W    = $clog2(STACK_DEPTH);
    localparam int LONG_HOLD = 300;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [REQ_W-1:0] REQ_MAX = 20'hFFFFF;

    // One result item as the block should present it.
    typedef struct packed {
        logic [OUT_W-1:0]  address;
        logic              address_valid;
        sca_pkg::status_t  status;
        logic [CNT_W-1:0]  chunk_count;
    } alloc_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind = '0;
    logic [REQ_W-1:0]      request_bytes = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [OUT_W-1:0]      address;
    logic                  address_valid;
    logic [STS_W-1:0]      status;
    logic [CNT_W-1:0]      chunk_count;
    logic                  cfg_we = 1'b0;
    logic [CAP_W-1:0]      cfg_wdata = '0;

    // Allocator state as the testbench believes it to be.
    logic [CAP_W-1:0]      model_capacity = sca_pkg::CAP_RESET;
    logic [OUT_W-1:0]      model_top_offset = '0;
    logic [REQ_W-1:0]      model_top_size = '0;
    logic [OUT_W-1:0]      model_used = '0;
    logic [CNT_W-1:0]      model_live = '0;
    logic [REQ_W-1:0]      model_sizes [STACK_DEPTH];

    alloc_result_t pending_results [$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request = 1'b0;

    stack_chunk_allocator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .request_bytes (request_bytes),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .address       (address),
        .address_valid (address_valid),
        .status        (status),
        .chunk_count   (chunk_count),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Applies one operation to the believed state and returns the result
    // item that the block owes for it.
    function automatic alloc_result_t predict_allocator(logic [KIND_W-1:0] op,
                                                        logic [REQ_W-1:0] req);
        logic [NEED_W-1:0] need;
        logic [NEED_W-1:0] room;
        logic [REQ_W-1:0]  below;
        sca_pkg::status_t  st;
        alloc_result_t     res;
        st = sca_pkg::ST_OK;
        case (op)
            sca_pkg::KIND_ALLOC:
            begin
                need = NEED_W'(req) + NEED_W'(HEADER);
                room = (model_capacity > model_used)
                     ? NEED_W'(model_capacity) - NEED_W'(model_used) : '0;
                // The space check wins over the depth check.
                if (need > room)
                    st = sca_pkg::ST_NO_SPACE;
                else if (model_live >= CNT_W'(STACK_DEPTH))
                    st = sca_pkg::ST_FULL;
                else
                begin
                    if (model_live == '0)
                        model_top_offset = '0;
                    else
                        model_top_offset = model_top_offset + OUT_W'(model_top_size)
                                         + OUT_W'(HEADER);
                    model_sizes[model_live[IDX_W-1:0]] = req;
                    model_live = model_live + CNT_W'(1);
                    model_top_size = req;
                    model_used = model_used + OUT_W'(need);
                end
            end
            sca_pkg::KIND_FREE:
            begin
                if (model_live == '0)
                    st = sca_pkg::ST_EMPTY;
                else
                begin
                    model_used = model_used - OUT_W'(model_top_size) - OUT_W'(HEADER);
                    model_live = model_live - CNT_W'(1);
                    if (model_live == '0)
                    begin
                        model_top_offset = '0;
                        model_top_size = '0;
                    end
                    else
                    begin
                        below = model_sizes[IDX_W'(model_live - CNT_W'(1))];
                        model_top_offset = model_top_offset - OUT_W'(below) - OUT_W'(HEADER);
                        model_top_size = below;
                    end
                end
            end
            sca_pkg::KIND_CLEAR:
            begin
                model_live = '0;
                model_top_offset = '0;
                model_top_size = '0;
                model_used = '0;
            end
            default:
            begin
                // The unused kind leaves everything alone.
            end
        endcase
        res.address = (model_live != '0) ? model_top_offset : '0;
        res.address_valid = (model_live != '0);
        res.status = st;
        res.chunk_count = model_live;
        return res;
    endfunction

    // Payload size that exactly fills the free bytes, or 0 if they do not cover a header.
    function automatic logic [REQ_W-1:0] exact_fit_bytes();
        logic [NEED_W-1:0] cap_ext;
        logic [NEED_W-1:0] used_ext;
        cap_ext = NEED_W'(model_capacity);
        used_ext = NEED_W'(model_used) + NEED_W'(HEADER);
        if (cap_ext >= used_ext)
            return REQ_W'(cap_ext - used_ext);
        return '0;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Offers one item, holds it until the block takes it, then records the
    // expected result.
    task automatic send_item(input logic [KIND_W-1:0] op, input logic [REQ_W-1:0] req);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        request_bytes <= req;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_allocator(op, req));
    endtask

    // Stops offering items until every expected result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        model_capacity = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Every operation, the unused kind, frees down to and past empty, clear
    // giving back the bytes, and an allocate that fills the region exactly.
    task automatic test_directed_operations();
        send_item(sca_pkg::KIND_FREE, '0);
        send_item(KIND_UNUSED, '0);
        send_item(sca_pkg::KIND_CLEAR, REQ_MAX);
        send_item(sca_pkg::KIND_ALLOC, '0);
        send_item(sca_pkg::KIND_ALLOC, REQ_MAX);
        send_item(sca_pkg::KIND_ALLOC, 20'd12);
        send_item(sca_pkg::KIND_ALLOC, 20'd100);
        send_item(KIND_UNUSED, REQ_MAX);
        send_item(sca_pkg::KIND_FREE, REQ_MAX);
        send_item(sca_pkg::KIND_FREE, '0);
        send_item(sca_pkg::KIND_FREE, '0);
        send_item(sca_pkg::KIND_ALLOC, 20'd7);
        send_item(sca_pkg::KIND_ALLOC, 20'd9);
        send_item(sca_pkg::KIND_CLEAR, '0);
        send_item(sca_pkg::KIND_ALLOC, 20'd5);
        send_item(sca_pkg::KIND_ALLOC, exact_fit_bytes());
        send_item(sca_pkg::KIND_ALLOC, '0);
        send_item(sca_pkg::KIND_CLEAR, '0);
    endtask

    // Zero capacity, a region that holds one bare header, and a capacity
    // lowered below the bytes already in use.
    task automatic test_capacity_extremes();
        write_capacity('0);
        send_item(sca_pkg::KIND_ALLOC, '0);
        send_item(sca_pkg::KIND_FREE, '0);
        write_capacity(20'd4);
        send_item(sca_pkg::KIND_ALLOC, '0);
        send_item(sca_pkg::KIND_ALLOC, '0);
        write_capacity(sca_pkg::CAP_RESET);
        send_item(sca_pkg::KIND_ALLOC, 20'd1000);
        send_item(sca_pkg::KIND_ALLOC, 20'd1000);
        write_capacity(20'd100);
        send_item(sca_pkg::KIND_ALLOC, '0);
        send_item(sca_pkg::KIND_FREE, '0);
        send_item(sca_pkg::KIND_CLEAR, '0);
    endtask

    // Fills the size stack, hits it once with an item that fits and once with
    // one that does not, then pops everything and one more.
    task automatic test_stack_limit();
        write_capacity(sca_pkg::CAP_RESET);
        send_item(sca_pkg::KIND_CLEAR, '0);
        repeat (STACK_DEPTH)
            send_item(sca_pkg::KIND_ALLOC, REQ_W'($urandom_range(0, 300)));
        send_item(sca_pkg::KIND_ALLOC, '0);
        send_item(sca_pkg::KIND_ALLOC, REQ_MAX);
        repeat (STACK_DEPTH + 1)
            send_item(sca_pkg::KIND_FREE, REQ_W'($urandom_range(0, REQ_MAX)));
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the block fills and stalls its input; then the sender waits it out.
    task automatic test_backpressure();
        int saved_pct;
        saved_pct = send_idle_pct;
        send_idle_pct = 0;
        hold_request = 1'b1;
        repeat (24)
        begin
            if ($urandom_range(2) != 0)
                send_item(sca_pkg::KIND_ALLOC, REQ_W'($urandom_range(0, 500)));
            else
                send_item(sca_pkg::KIND_FREE, '0);
        end
        send_idle_pct = saved_pct;
        wait_drained();
    endtask

    // Random items biased toward small allocates so the stack grows deep,
    // with frees, clears, large requests, exact fits and the unused kind.
    task automatic test_random_mix(input int count, input logic [CAP_W-1:0] cap,
                                   input int small_max);
        int roll;
        write_capacity(cap);
        repeat (count)
        begin
            roll = int'($urandom_range(99));
            if (roll < 50)
                send_item(sca_pkg::KIND_ALLOC, REQ_W'($urandom_range(0, small_max)));
            else if (roll < 54)
                send_item(sca_pkg::KIND_ALLOC, REQ_W'($urandom_range(0, REQ_MAX)));
            else if (roll < 58)
                send_item(sca_pkg::KIND_ALLOC, exact_fit_bytes());
            else if (roll < 86)
                send_item(sca_pkg::KIND_FREE, REQ_W'($urandom_range(0, REQ_MAX)));
            else if (roll < 90)
                send_item(sca_pkg::KIND_CLEAR, REQ_W'($urandom_range(0, REQ_MAX)));
            else if (roll < 93)
                send_item(KIND_UNUSED, REQ_W'($urandom_range(0, REQ_MAX)));
            else
                send_item(sca_pkg::KIND_ALLOC, REQ_W'($urandom_range(0, 20)));
        end
    endtask

    // Result side: random stalls, or one long hold when a test asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                repeat (LONG_HOLD)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= (int'($urandom_range(99)) < recv_idle_pct);
        end
    end

    // Each accepted result is matched against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no item waiting for it");
            else
            begin
                want = pending_results.pop_front();
                if (address !== want.address)
                    report_mismatch($sformatf("address exp %0h got %0h",
                                              want.address, address));
                if (address_valid !== want.address_valid)
                    report_mismatch($sformatf("address_valid exp %0b got %0b",
                                              want.address_valid, address_valid));
                if (status !== want.status)
                    report_mismatch($sformatf("status exp %0d got %0d",
                                              want.status, status));
                if (chunk_count !== want.chunk_count)
                    report_mismatch($sformatf("chunk_count exp %0d got %0d",
                                              want.chunk_count, chunk_count));
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender mostly busy, receiver mostly stalled.
        send_idle_pct = 9;
        recv_idle_pct = 68;
        test_directed_operations();
        test_capacity_extremes();
        test_random_mix(100, sca_pkg::CAP_RESET, 2000);

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 68;
        recv_idle_pct = 9;
        test_random_mix(100, 20'd20000, 400);
        test_backpressure();

        // Full rate in both directions.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(80, 20'd3000, 120);
        test_stack_limit();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
